// ----- sv/periodic_timer_bank_macros.svh -----
// ---------------------------------------------------------------------------
// Periodic timer bank assertion macros
// Concurrent assertion wrappers clocked on aclk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_BANK_MACROS_SVH
`define PERIODIC_TIMER_BANK_MACROS_SVH
`ifndef SYNTH
`define PTB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);
`define PTB_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);
`else
`define PTB_ASSERT(lbl, prop, msg)
`define PTB_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- sv/ptb_pkg.sv -----
// ---------------------------------------------------------------------------
// Periodic timer bank package
// Item types, operation codes and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package ptb_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [31:0] NOT_FOUND_ID = 32'hFFFF_FFFF;

    // input item kinds
    localparam logic [2:0] KIND_CREATE  = 3'd0;
    localparam logic [2:0] KIND_START   = 3'd1;
    localparam logic [2:0] KIND_PAUSE   = 3'd2;
    localparam logic [2:0] KIND_DESTROY = 3'd3;
    localparam logic [2:0] KIND_FIND    = 3'd4;
    localparam logic [2:0] KIND_TICK    = 3'd5;

    // result kinds
    localparam logic [1:0] RES_CREATED = 2'd0;
    localparam logic [1:0] RES_FULL    = 2'd1;
    localparam logic [1:0] RES_FOUND   = 2'd2;
    localparam logic [1:0] RES_EXPIRED = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] timer_id;
        logic [15:0] task_id;
        logic [31:0] interval;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] result_timer;
        logic [15:0] result_task;
        logic        found;
        logic        last;
    } out_item_t;

    typedef enum logic [3:0] {
        DP_NOP       = 4'd0,
        DP_CREATE    = 4'd1,
        DP_LOOKUP    = 4'd2,
        DP_FIND      = 4'd3,
        DP_FIND_EMIT = 4'd4,
        DP_TICK_UPD  = 4'd5,
        DP_SEL       = 4'd6,
        DP_SEL_EMIT  = 4'd7
    } dp_op_t;

    typedef struct packed {
        logic   load;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic hit;
        logic fire_any;
        logic fire_rest;
        logic out_free;
    } dp_sts_t;

endpackage

// ----- sv/ptb_ctrl.sv -----
// ---------------------------------------------------------------------------
// Periodic timer bank controller
// Sequences slot scans for each item and issues datapath commands.
// ---------------------------------------------------------------------------
module ptb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_kind,
    input  ptb_pkg::dp_sts_t  sts,
    output ptb_pkg::dp_cmd_t  cmd
);
    import ptb_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_CREATE   = 8'b0000_0010,
        ST_LOOKUP   = 8'b0000_0100,
        ST_FIND     = 8'b0000_1000,
        ST_FIND_OUT = 8'b0001_0000,
        ST_TICK_UPD = 8'b0010_0000,
        ST_TICK_SEL = 8'b0100_0000,
        ST_TICK_OUT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.op     = DP_NOP;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    case (s_kind)
                        KIND_CREATE:  state_next = ST_CREATE;
                        KIND_START:   state_next = ST_LOOKUP;
                        KIND_PAUSE:   state_next = ST_LOOKUP;
                        KIND_DESTROY: state_next = ST_LOOKUP;
                        KIND_FIND:    state_next = ST_FIND;
                        KIND_TICK:    state_next = ST_TICK_UPD;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CREATE: begin
                if (sts.out_free) begin
                    cmd.op     = DP_CREATE;
                    state_next = ST_IDLE;
                end
            end
            ST_LOOKUP: begin
                cmd.op = DP_LOOKUP;
                if (sts.hit || sts.scan_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIND: begin
                cmd.op = DP_FIND;
                if (sts.scan_last) begin
                    state_next = ST_FIND_OUT;
                end
            end
            ST_FIND_OUT: begin
                if (sts.out_free) begin
                    cmd.op     = DP_FIND_EMIT;
                    state_next = ST_IDLE;
                end
            end
            ST_TICK_UPD: begin
                cmd.op = DP_TICK_UPD;
                if (sts.scan_last) begin
                    state_next = ST_TICK_SEL;
                end
            end
            ST_TICK_SEL: begin
                if (!sts.fire_any) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.op = DP_SEL;
                    if (sts.scan_last) begin
                        state_next = ST_TICK_OUT;
                    end
                end
            end
            ST_TICK_OUT: begin
                if (sts.out_free) begin
                    cmd.op     = DP_SEL_EMIT;
                    state_next = sts.fire_rest ? ST_TICK_SEL : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/ptb_dp.sv -----
// ---------------------------------------------------------------------------
// Periodic timer bank datapath
// Slot table, scan index, best-candidate tracking and result register.
// ---------------------------------------------------------------------------
`include "periodic_timer_bank_macros.svh"

module ptb_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  ptb_pkg::in_item_t  s_item,
    input  ptb_pkg::dp_cmd_t   cmd,
    output ptb_pkg::dp_sts_t   sts,
    output logic               m_valid,
    input  logic               m_ready,
    output ptb_pkg::out_item_t m_item
);
    import ptb_pkg::*;

    // slot table
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [SLOTS-1:0] running_reg, running_next;
    logic [SLOTS-1:0] fire_reg, fire_next;
    logic [31:0]      slot_ident_reg  [SLOTS];
    logic [15:0]      slot_owner_reg  [SLOTS];
    logic [31:0]      slot_period_reg [SLOTS];
    logic [31:0]      slot_ticks_reg  [SLOTS];
    logic [31:0]      next_ident_reg, next_ident_next;

    // item and scan
    in_item_t         in_reg, in_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic             best_v_reg, best_v_next;
    logic [31:0]      best_id_reg, best_id_next;
    logic [15:0]      best_owner_reg, best_owner_next;
    logic [SLOT_W-1:0] best_slot_reg, best_slot_next;

    // result
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;

    logic              free_any;
    logic [SLOT_W-1:0] free_slot;
    logic              cur_valid, cur_running, cur_fire;
    logic [31:0]       cur_ident, cur_period, cur_ticks;
    logic [15:0]       cur_owner;
    logic              scan_last, hit, find_hit, sel_hit, out_free;
    logic [SLOTS-1:0]  best_mask;
    logic              fire_rest;
    logic [SLOT_W-1:0] idx_step;

    // lowest free slot
    always_comb begin
        free_any  = 1'b0;
        free_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_any  = 1'b1;
                free_slot = SLOT_W'(i);
            end
        end
    end

    assign cur_valid   = valid_reg[idx_reg];
    assign cur_running = running_reg[idx_reg];
    assign cur_ident   = slot_ident_reg[idx_reg];
    assign cur_owner   = slot_owner_reg[idx_reg];
    assign cur_period  = slot_period_reg[idx_reg];
    assign cur_ticks   = slot_ticks_reg[idx_reg];
    assign cur_fire    = cur_valid && cur_running && (cur_ticks == cur_period);

    assign scan_last = (idx_reg == SLOT_W'(SLOTS - 1));
    assign idx_step  = scan_last ? '0 : idx_reg + SLOT_W'(1);
    assign hit       = cur_valid && (cur_ident == in_reg.timer_id);
    assign find_hit  = cur_valid && (cur_owner == in_reg.task_id) &&
                       (!best_v_reg || (cur_ident < best_id_reg));
    assign sel_hit   = fire_reg[idx_reg] && (!best_v_reg || (cur_ident < best_id_reg));
    assign best_mask = SLOTS'(1) << best_slot_reg;
    assign fire_rest = (fire_reg & ~best_mask) != '0;
    assign out_free  = !out_valid_reg || m_ready;

    assign sts.scan_last = scan_last;
    assign sts.hit       = hit;
    assign sts.fire_any  = (fire_reg != '0);
    assign sts.fire_rest = fire_rest;
    assign sts.out_free  = out_free;

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    always_comb begin
        valid_next      = valid_reg;
        running_next    = running_reg;
        fire_next       = fire_reg;
        next_ident_next = next_ident_reg;
        in_next         = in_reg;
        idx_next        = idx_reg;
        best_v_next     = best_v_reg;
        best_id_next    = best_id_reg;
        best_owner_next = best_owner_reg;
        best_slot_next  = best_slot_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_next        = out_reg;

        if (cmd.load) begin
            in_next     = s_item;
            idx_next    = '0;
            best_v_next = 1'b0;
        end

        case (cmd.op)
            DP_CREATE: begin
                out_valid_next = 1'b1;
                out_next       = '0;
                out_next.last  = 1'b1;
                if (free_any) begin
                    valid_next[free_slot]   = 1'b1;
                    running_next[free_slot] = 1'b0;
                    next_ident_next         = next_ident_reg + 32'd1;
                    out_next.result_kind    = RES_CREATED;
                    out_next.result_timer   = next_ident_reg + 32'd1;
                end else begin
                    out_next.result_kind = RES_FULL;
                end
            end
            DP_LOOKUP: begin
                idx_next = idx_step;
                if (hit) begin
                    case (in_reg.kind)
                        KIND_START: running_next[idx_reg] = 1'b1;
                        KIND_PAUSE: running_next[idx_reg] = 1'b0;
                        KIND_DESTROY: begin
                            valid_next[idx_reg]   = 1'b0;
                            running_next[idx_reg] = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            DP_FIND: begin
                idx_next = idx_step;
                if (find_hit) begin
                    best_v_next  = 1'b1;
                    best_id_next = cur_ident;
                end
            end
            DP_FIND_EMIT: begin
                out_valid_next        = 1'b1;
                out_next.result_kind  = RES_FOUND;
                out_next.result_timer = best_v_reg ? best_id_reg : NOT_FOUND_ID;
                out_next.result_task  = '0;
                out_next.found        = best_v_reg;
                out_next.last         = 1'b1;
            end
            DP_TICK_UPD: begin
                idx_next           = idx_step;
                fire_next[idx_reg] = cur_fire;
            end
            DP_SEL: begin
                idx_next = idx_step;
                if (sel_hit) begin
                    best_v_next     = 1'b1;
                    best_id_next    = cur_ident;
                    best_owner_next = cur_owner;
                    best_slot_next  = idx_reg;
                end
            end
            DP_SEL_EMIT: begin
                out_valid_next        = 1'b1;
                out_next.result_kind  = RES_EXPIRED;
                out_next.result_timer = best_id_reg;
                out_next.result_task  = best_owner_reg;
                out_next.found        = 1'b0;
                out_next.last         = !fire_rest;
                fire_next             = fire_reg & ~best_mask;
                best_v_next           = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            running_reg    <= '0;
            fire_reg       <= '0;
            next_ident_reg <= '0;
            idx_reg        <= '0;
            best_v_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            running_reg    <= running_next;
            fire_reg       <= fire_next;
            next_ident_reg <= next_ident_next;
            idx_reg        <= idx_next;
            best_v_reg     <= best_v_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg         <= in_next;
        best_id_reg    <= best_id_next;
        best_owner_reg <= best_owner_next;
        best_slot_reg  <= best_slot_next;
        out_reg        <= out_next;
    end

    // slot payload: create fills a free slot, tick updates the scanned count
    always_ff @(posedge aclk) begin
        if (cmd.op == DP_CREATE && free_any) begin
            slot_ident_reg[free_slot]  <= next_ident_reg + 32'd1;
            slot_owner_reg[free_slot]  <= in_reg.task_id;
            slot_period_reg[free_slot] <= in_reg.interval;
            slot_ticks_reg[free_slot]  <= '0;
        end
        if (cmd.op == DP_TICK_UPD && cur_valid && cur_running) begin
            slot_ticks_reg[idx_reg] <= cur_fire ? 32'd1 : cur_ticks + 32'd1;
        end
    end

    `PTB_ASSERT(a_create_claims_slot, (cmd.op == DP_CREATE && free_any) |=> $countones(valid_reg) == $past($countones(valid_reg)) + 1, "create did not claim exactly one slot")
    `PTB_ASSERT_NEVER(a_running_is_valid, (running_reg & ~valid_reg) != '0, "running flag on a free slot")
    `PTB_ASSERT_NEVER(a_fire_is_running, (fire_reg & ~running_reg) != '0, "expiry pending on a stopped slot")

endmodule

// ----- sv/periodic_timer_bank.sv -----
// ---------------------------------------------------------------------------
// Periodic timer bank
// Table of periodic timers with create, start, pause, destroy, find and tick.
// ---------------------------------------------------------------------------
// One item is handled at a time; every command except create walks the slot
// table one slot per cycle, with S slots (16 here). Start/pause/destroy stop at
// the matching slot, find and tick walk the whole table, and a tick then picks
// each expiring timer in id order by a fresh pass of the shared compare unit
// over the table. A waiting result in the output register holds the block back
// only when the next result is ready to be loaded.
module periodic_timer_bank (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ptb_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output ptb_pkg::out_item_t m_item
);
    import ptb_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    ptb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_item.kind),
        .sts     (sts),
        .cmd     (cmd)
    );

    ptb_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

// ----- tb/sv/periodic_timer_bank_tb.sv -----
// ---------------------------------------------------------------------------
// Periodic timer bank testbench
// Drives create, start, pause, destroy, find and tick items into the timer
// bank. A directed script covers empty-table answers, the first ids, a full
// table and the unused kinds. Random traffic follows, with some arm-and-tick
// bursts over live timers. A local model of the slot table predicts every
// result, and each result is checked field by field in order of arrival.
// Random idle bursts fall on both sides. At one point the result side holds
// off for a long stretch so that the block backs up into its input.
// ---------------------------------------------------------------------------
module periodic_timer_bank_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptb_pkg::*;

    localparam int ITEM_TARGET  = 370;
    localparam int CALM_TAIL    = 60;
    localparam int HOLD_AT_ITEM = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
    localparam int STALL_LIMIT  = 4000;

    // kinds that the block ignores
    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    typedef struct {
        in_item_t  cmd;
        int        reps;
        bit        typed;
        out_item_t result;
    } directed_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // model of the slot table
    bit        slot_live     [SLOTS];
    bit        slot_armed    [SLOTS];
    bit [31:0] slot_id       [SLOTS];
    bit [15:0] slot_task     [SLOTS];
    bit [31:0] slot_interval [SLOTS];
    bit [31:0] slot_count    [SLOTS];
    bit [31:0] last_issued_id;

    out_item_t awaited_results[$];
    int        mismatches   = 0;
    int        quiet_cycles = 0;
    int        idle_pct     = 20;
    bit        hold_req     = 1'b0;
    bit        hold_done    = 1'b0;

    periodic_timer_bank dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #2 aclk = ~aclk;

    function automatic int slot_of_id(logic [31:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && slot_id[i] == id)
                return i;
        return -1;
    endfunction

    // Advance the table model by one item and queue the results it causes.
    function automatic void apply_timer_cmd(in_item_t cmd);
        int        hit;
        int        pick;
        int        n_fire;
        bit        fires [SLOTS];
        bit        sent  [SLOTS];
        out_item_t res;
        hit    = -1;
        n_fire = 0;
        res    = '0;
        case (cmd.kind)
            KIND_CREATE: begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!slot_live[i])
                        hit = i;
                res.last = 1'b1;
                if (hit < 0) begin
                    res.result_kind = RES_FULL;
                end else begin
                    last_issued_id++;
                    slot_live[hit]     = 1'b1;
                    slot_armed[hit]    = 1'b0;
                    slot_id[hit]       = last_issued_id;
                    slot_task[hit]     = cmd.task_id;
                    slot_interval[hit] = cmd.interval;
                    slot_count[hit]    = '0;
                    res.result_kind    = RES_CREATED;
                    res.result_timer   = last_issued_id;
                end
                awaited_results.push_back(res);
            end
            KIND_START, KIND_PAUSE, KIND_DESTROY: begin
                hit = slot_of_id(cmd.timer_id);
                if (hit >= 0) begin
                    slot_armed[hit] = (cmd.kind == KIND_START);
                    if (cmd.kind == KIND_DESTROY)
                        slot_live[hit] = 1'b0;
                end
            end
            KIND_FIND: begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_live[i] && slot_task[i] == cmd.task_id &&
                        (hit < 0 || slot_id[i] < slot_id[hit]))
                        hit = i;
                res.result_kind = RES_FOUND;
                res.last        = 1'b1;
                if (hit < 0) begin
                    res.result_timer = NOT_FOUND_ID;
                end else begin
                    res.result_timer = slot_id[hit];
                    res.found        = 1'b1;
                end
                awaited_results.push_back(res);
            end
            KIND_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    fires[i] = slot_live[i] && slot_armed[i] &&
                               slot_count[i] == slot_interval[i];
                    sent[i]  = 1'b0;
                    if (fires[i])
                        n_fire++;
                end
                // emit in creation order; equal ids go to the lower slot
                for (int k = 0; k < n_fire; k++) begin
                    pick = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (fires[i] && !sent[i] && (pick < 0 || slot_id[i] < slot_id[pick]))
                            pick = i;
                    sent[pick]       = 1'b1;
                    res              = '0;
                    res.result_kind  = RES_EXPIRED;
                    res.result_timer = slot_id[pick];
                    res.result_task  = slot_task[pick];
                    res.last         = (k == n_fire - 1);
                    awaited_results.push_back(res);
                end
                for (int i = 0; i < SLOTS; i++) begin
                    if (fires[i])
                        slot_count[i] = '0;
                    if (slot_live[i] && slot_armed[i])
                        slot_count[i] = slot_count[i] + 1;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic directed_row_t row(logic [2:0] kind, logic [31:0] tmr,
                                          logic [15:0] tsk, logic [31:0] ivl, int reps,
                                          bit typed, logic [1:0] rkind,
                                          logic [31:0] rtimer, logic rfound);
        directed_row_t r;
        r.cmd.kind            = kind;
        r.cmd.timer_id        = tmr;
        r.cmd.task_id         = tsk;
        r.cmd.interval        = ivl;
        r.reps                = reps;
        r.typed               = typed;
        r.result              = '0;
        r.result.result_kind  = rkind;
        r.result.result_timer = rtimer;
        r.result.found        = rfound;
        r.result.last         = 1'b1;
        return r;
    endfunction

    task automatic offer_item(input in_item_t cmd, input bit typed, input out_item_t typed_res);
        s_item  <= cmd;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        apply_timer_cmd(cmd);
        // a typed row carries its one result by hand
        if (typed)
            awaited_results[awaited_results.size() - 1] = typed_res;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic make_random_cmd(output in_item_t cmd, output bit counts);
        int roll;
        int start_at;
        int idx;
        cmd.kind     = KIND_TICK;
        cmd.timer_id = $urandom;
        cmd.task_id  = 16'($urandom_range(0, 16'hFFFF));
        cmd.interval = $urandom;
        counts       = 1'b1;
        roll         = $urandom_range(0, 99);
        if (roll < 18) begin
            cmd.kind = KIND_CREATE;
            if ($urandom_range(0, 4) != 0)
                cmd.task_id = 16'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0:       cmd.interval = $urandom;
                1, 2:    cmd.interval = $urandom_range(5, 40);
                default: cmd.interval = $urandom_range(0, 4);
            endcase
        end else if (roll < 56) begin
            cmd.kind = (roll < 38) ? KIND_START : (roll < 46) ? KIND_PAUSE : KIND_DESTROY;
            if ($urandom_range(0, 6) != 0) begin
                start_at = $urandom_range(0, SLOTS - 1);
                for (int k = 0; k < SLOTS; k++) begin
                    idx = (start_at + k) % SLOTS;
                    if (slot_live[idx]) begin
                        cmd.timer_id = slot_id[idx];
                        break;
                    end
                end
            end
            counts = (slot_of_id(cmd.timer_id) >= 0);
        end else if (roll < 64) begin
            cmd.kind = KIND_FIND;
            if ($urandom_range(0, 3) != 0)
                cmd.task_id = 16'($urandom_range(0, 3));
        end else if (roll >= 97) begin
            cmd.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            counts   = 1'b0;
        end
    endtask

    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        mismatches++;
    endtask

    // result side: check each item against the oldest prediction
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %p",
                             $time, m_item);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_item.result_kind !== want.result_kind)
                        flag_field("result_kind", 32'(want.result_kind),
                                   32'(m_item.result_kind));
                    if (m_item.result_timer !== want.result_timer)
                        flag_field("result_timer", want.result_timer, m_item.result_timer);
                    if (m_item.result_task !== want.result_task)
                        flag_field("result_task", 32'(want.result_task),
                                   32'(m_item.result_task));
                    if (m_item.found !== want.found)
                        flag_field("found", 32'(want.found), 32'(m_item.found));
                    if (m_item.last !== want.last)
                        flag_field("last", 32'(want.last), 32'(m_item.last));
                end
            end
        end
    end

    // result side ready: random stalls plus one long hold-off
    initial begin
        @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        directed_row_t script[$];
        in_item_t      cmd;
        bit            counts;
        int            effective;
        effective = 0;

        script.push_back(row(KIND_FIND, 0, 0, 0, 1, 1, RES_FOUND, NOT_FOUND_ID, 1'b0));
        script.push_back(row(KIND_TICK, 0, 0, 0, 1, 0, RES_CREATED, 0, 1'b0));
        script.push_back(row(KIND_START, 32'hFFFF_FFFF, 0, 0, 1, 0, RES_CREATED, 0, 1'b0));
        script.push_back(row(KIND_CREATE, 0, 16'hFFFF, 0, 1, 1, RES_CREATED, 1, 1'b0));
        script.push_back(row(KIND_CREATE, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1, 1,
                             RES_CREATED, 2, 1'b0));
        script.push_back(row(KIND_CREATE, 0, 16'hFFFF, 1, 1, 1, RES_CREATED, 3, 1'b0));
        script.push_back(row(KIND_FIND, 0, 16'hFFFF, 0, 1, 1, RES_FOUND, 1, 1'b1));
        script.push_back(row(KIND_START, 1, 0, 0, 1, 0, RES_CREATED, 0, 1'b0));
        script.push_back(row(KIND_START, 3, 0, 0, 1, 0, RES_CREATED, 0, 1'b0));
        script.push_back(row(KIND_TICK, 0, 0, 0, 3, 0, RES_CREATED, 0, 1'b0));
        script.push_back(row(KIND_PAUSE, 3, 0, 0, 1, 0, RES_CREATED, 0, 1'b0));
        script.push_back(row(KIND_TICK, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1, 0,
                             RES_CREATED, 0, 1'b0));
        script.push_back(row(KIND_DESTROY, 1, 0, 0, 1, 0, RES_CREATED, 0, 1'b0));
        script.push_back(row(KIND_FIND, 0, 16'hFFFF, 0, 1, 1, RES_FOUND, 3, 1'b1));
        script.push_back(row(KIND_START, 2, 0, 0, 1, 0, RES_CREATED, 0, 1'b0));
        script.push_back(row(KIND_SPARE_LO, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1, 0,
                             RES_CREATED, 0, 1'b0));
        script.push_back(row(KIND_SPARE_HI, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1, 0,
                             RES_CREATED, 0, 1'b0));
        // fill every free slot, then one more to hit the full table
        script.push_back(row(KIND_CREATE, 0, 16'h5A5A, 0, SLOTS - 2, 0, RES_CREATED, 0, 1'b0));
        script.push_back(row(KIND_CREATE, 0, 16'h1234, 0, 1, 1, RES_FULL, 0, 1'b0));
        script.push_back(row(KIND_DESTROY, 2, 0, 0, 1, 0, RES_CREATED, 0, 1'b0));
        script.push_back(row(KIND_TICK, 0, 0, 0, 1, 0, RES_CREATED, 0, 1'b0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[r])
            repeat (script[r].reps) begin
                offer_item(script[r].cmd, script[r].typed, script[r].result);
                effective++;
            end

        while (effective < ITEM_TARGET) begin
            if (ITEM_TARGET - effective <= CALM_TAIL)
                idle_pct = 0;
            else if ($urandom_range(0, 29) == 0)
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    default: idle_pct = 35;
                endcase
            if (effective >= HOLD_AT_ITEM)
                hold_req = 1'b1;

            if ($urandom_range(0, 9) == 0) begin
                // arm every live timer, then let a few ticks go by
                for (int i = 0; i < SLOTS; i++)
                    if (slot_live[i]) begin
                        cmd.kind     = KIND_START;
                        cmd.timer_id = slot_id[i];
                        cmd.task_id  = 16'($urandom_range(0, 16'hFFFF));
                        cmd.interval = $urandom;
                        offer_item(cmd, 1'b0, '0);
                        effective++;
                    end
                repeat ($urandom_range(1, 4)) begin
                    cmd.kind     = KIND_TICK;
                    cmd.timer_id = $urandom;
                    cmd.task_id  = 16'($urandom_range(0, 16'hFFFF));
                    cmd.interval = $urandom;
                    offer_item(cmd, 1'b0, '0);
                    effective++;
                end
            end else begin
                make_random_cmd(cmd, counts);
                offer_item(cmd, 1'b0, '0);
                if (counts)
                    effective++;
            end
        end

        s_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
